// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the motion order mode selector RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/moms_pkg.sv =====
// ----------------------------------------------------------------------------
// moms_pkg
// Types, codes and constants of the motion order mode selector.
// ----------------------------------------------------------------------------
package moms_pkg;

  // Tolerances and timeouts
  localparam int unsigned DIST_ACCURACY  = 10;
  localparam int unsigned HEAD_TOL_UNITS = 182;
  localparam int unsigned PASS_HOLD_MS   = 1000;
  localparam int unsigned ORDER_LIMIT_MS = 10000;

  // Derived compare constants
  localparam logic [32:0]        DIST_ACC_SQ = 33'(DIST_ACCURACY * DIST_ACCURACY);
  localparam logic [16:0]        ANGLE_ACC   = 17'(HEAD_TOL_UNITS);
  localparam logic signed [31:0] PASS_TMO    = 32'(PASS_HOLD_MS);
  localparam logic signed [31:0] ORDER_TMO   = 32'(ORDER_LIMIT_MS);

  // Order mode codes
  localparam logic [2:0] OM_INIT     = 3'd0;
  localparam logic [2:0] OM_RUN      = 3'd1;
  localparam logic [2:0] OM_APPROACH = 3'd2;
  localparam logic [2:0] OM_DONE     = 3'd3;
  localparam logic [2:0] OM_ERROR    = 3'd4;
  localparam logic [2:0] OM_PASS     = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_X         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_Y         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_HEADING     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_MODE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_INIT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_APPROACH = 3'd7;

  typedef struct packed {
    logic              restart;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        pos_heading;
    logic [30:0]        now_time;
  } moms_in_t;

  typedef struct packed {
    logic [2:0] order_mode;
    logic       mode_changed;
  } moms_out_t;

  typedef struct packed {
    logic signed [15:0] begin_x;
    logic signed [15:0] begin_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [15:0]        end_heading;
    logic               pass_mode;
    logic [15:0]        radius_init;
    logic [15:0]        radius_approach;
  } moms_cfg_t;

  // Squared terms and checks handed from the geometry stage to the mode stage
  typedef struct packed {
    logic        restart;
    logic [30:0] now_time;
    logic [31:0] sq_bx;
    logic [31:0] sq_by;
    logic [31:0] sq_ex;
    logic [31:0] sq_ey;
    logic [31:0] ri_sq;
    logic [31:0] ra_sq;
    logic        head_ok;
  } moms_geom_t;

endpackage

// ===== hdl/motion_order_mode_selector_unit.sv =====
// ----------------------------------------------------------------------------
// motion_order_mode_selector_unit
// Supervises one motion order and reports its mode for each pose sample.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | moms_in_t: restart, pose, time
//  out_    | output    | out_valid / out_ready | moms_out_t: order_mode, mode_changed
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index (3 bits), cfg_data (16 bits)
//
// Three stages: input register, geometry (squares) register, result register.
// One sample per cycle unless the output stalls; a sample passes the input, geometry
// and result registers. Mode state advances as a sample enters the result register.
// Reset (rst_n low, synchronous) empties the pipe and clears mode and timers.
// A stalled output holds its result; empty stages upstream still fill.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motion_order_mode_selector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  moms_pkg::moms_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output moms_pkg::moms_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [moms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  moms_pkg::moms_cfg_t  cfg;
  moms_pkg::moms_in_t   s0_data_r;
  moms_pkg::moms_geom_t geom;
  logic s0_valid_r, s1_valid_r, out_valid_r;
  logic s0_en, s1_en, out_en, upd;
  logic [2:0] mode;

  // Stage enables: a stage loads when empty or when its content moves on
  assign out_en   = !out_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || out_en;
  assign s0_en    = !s0_valid_r || s1_en;
  assign upd      = s1_valid_r && out_en;
  assign in_ready = s0_en;
  assign out_valid = out_valid_r;

  // Advance valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s0_en)  s0_valid_r  <= in_valid;
      if (s1_en)  s1_valid_r  <= s0_valid_r;
      if (out_en) out_valid_r <= s1_valid_r;
    end
  end

  // Capture the input transfer
  always_ff @(posedge clk) begin
    if (in_valid && s0_en) begin
      s0_data_r <= in_data;
    end
  end

  moms_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_q     (cfg)
  );

  moms_geom u_geom (
    .clk (clk),
    .en  (s1_en),
    .d   (s0_data_r),
    .cfg (cfg),
    .q   (geom)
  );

  moms_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .g         (geom),
    .pass_mode (cfg.pass_mode),
    .q         (out_data),
    .mode_o    (mode)
  );

  // Checks on the mode stage
  `ASSERT_CLK(a_restart_init, upd && geom.restart |=> mode == moms_pkg::OM_INIT, "restart did not return to INIT")
  `ASSERT_CLK(a_changed_flag, upd |=> out_data.mode_changed == (mode != $past(mode)) && out_data.order_mode == mode, "result does not match mode update")
  `ASSERT_CLK(a_final_hold, upd && !geom.restart && (mode == moms_pkg::OM_DONE || mode == moms_pkg::OM_ERROR) |=> $stable(mode), "final mode left without restart")
  `ASSERT_ALWAYS(a_mode_idle, rst_n && $past(rst_n) && !$past(upd) |-> $stable(mode), "mode changed without an item")

endmodule

// ===== hdl/moms_cfg.sv =====
// ----------------------------------------------------------------------------
// moms_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module moms_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [moms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output moms_pkg::moms_cfg_t           cfg_q
);

  moms_pkg::moms_cfg_t cfg_r;
  moms_pkg::moms_cfg_t cfg_nxt;

  // Always able to take a write
  assign cfg_ready = 1'b1;
  assign cfg_q     = cfg_r;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        moms_pkg::CFG_BEGIN_X:         cfg_nxt.begin_x         = cfg_data;
        moms_pkg::CFG_BEGIN_Y:         cfg_nxt.begin_y         = cfg_data;
        moms_pkg::CFG_END_X:           cfg_nxt.end_x           = cfg_data;
        moms_pkg::CFG_END_Y:           cfg_nxt.end_y           = cfg_data;
        moms_pkg::CFG_END_HEADING:     cfg_nxt.end_heading     = cfg_data;
        moms_pkg::CFG_PASS_MODE:       cfg_nxt.pass_mode       = cfg_data[0];
        moms_pkg::CFG_RADIUS_INIT:     cfg_nxt.radius_init     = cfg_data;
        moms_pkg::CFG_RADIUS_APPROACH: cfg_nxt.radius_approach = cfg_data;
        default:                       cfg_nxt                 = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/moms_geom.sv =====
// ----------------------------------------------------------------------------
// moms_geom
// Geometry stage: coordinate differences, squares and heading error check.
// ----------------------------------------------------------------------------
module moms_geom (
  input  logic                 clk,
  input  logic                 en,
  input  moms_pkg::moms_in_t   d,
  input  moms_pkg::moms_cfg_t  cfg,
  output moms_pkg::moms_geom_t q
);

  logic signed [16:0] dbx, dby, dex, dey;
  logic signed [33:0] pbx, pby, pex, pey;
  logic [15:0]        herr;
  logic signed [16:0] hs;
  logic [16:0]        habs;
  moms_pkg::moms_geom_t geom_r;
  moms_pkg::moms_geom_t geom_nxt;

  // Differences from the begin point and to the target point
  always_comb begin
    dbx = $signed({d.pos_x[15], d.pos_x}) - $signed({cfg.begin_x[15], cfg.begin_x});
    dby = $signed({d.pos_y[15], d.pos_y}) - $signed({cfg.begin_y[15], cfg.begin_y});
    dex = $signed({cfg.end_x[15], cfg.end_x}) - $signed({d.pos_x[15], d.pos_x});
    dey = $signed({cfg.end_y[15], cfg.end_y}) - $signed({d.pos_y[15], d.pos_y});
  end

  // Squares; each fits in 32 bits since |difference| <= 65535
  assign pbx = dbx * dbx;
  assign pby = dby * dby;
  assign pex = dex * dex;
  assign pey = dey * dey;

  // Wrapped heading error and its magnitude
  always_comb begin
    herr = cfg.end_heading - d.pos_heading;
    hs   = $signed({herr[15], herr});
    habs = hs[16] ? 17'(-hs) : 17'(hs);
  end

  always_comb begin
    geom_nxt.restart  = d.restart;
    geom_nxt.now_time = d.now_time;
    geom_nxt.sq_bx    = pbx[31:0];
    geom_nxt.sq_by    = pby[31:0];
    geom_nxt.sq_ex    = pex[31:0];
    geom_nxt.sq_ey    = pey[31:0];
    geom_nxt.ri_sq    = {16'd0, cfg.radius_init} * {16'd0, cfg.radius_init};
    geom_nxt.ra_sq    = {16'd0, cfg.radius_approach} * {16'd0, cfg.radius_approach};
    geom_nxt.head_ok  = habs < moms_pkg::ANGLE_ACC;
  end

  // Hold the stage while downstream stalls
  always_ff @(posedge clk) begin
    if (en) begin
      geom_r <= geom_nxt;
    end
  end

  assign q = geom_r;

endmodule

// ===== hdl/moms_fsm.sv =====
// ----------------------------------------------------------------------------
// moms_fsm
// Mode stage: distance compares, timers, order mode and result register.
// ----------------------------------------------------------------------------
module moms_fsm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  moms_pkg::moms_geom_t g,
  input  logic                 pass_mode,
  output moms_pkg::moms_out_t  q,
  output logic [2:0]           mode_o
);

  logic [2:0]  mode_r, mode_nxt;
  logic [30:0] ost_r, ost_nxt;
  logic        osv_r, osv_nxt;
  logic [30:0] pst_r, pst_nxt;
  moms_pkg::moms_out_t res_r;
  logic [32:0]        d_begin, d_end;
  logic signed [31:0] order_dt, pass_dt;
  logic leave_init, near_target, at_target, order_tmo, pass_over;

  // Squared distances and compares
  always_comb begin
    d_begin     = {1'b0, g.sq_bx} + {1'b0, g.sq_by};
    d_end       = {1'b0, g.sq_ex} + {1'b0, g.sq_ey};
    leave_init  = d_begin >= {1'b0, g.ri_sq};
    near_target = d_end <= {1'b0, g.ra_sq};
    at_target   = (d_end < moms_pkg::DIST_ACC_SQ) && g.head_ok;
  end

  // Elapsed times as signed differences
  always_comb begin
    order_dt  = $signed({1'b0, g.now_time}) - $signed({1'b0, ost_r});
    pass_dt   = $signed({1'b0, g.now_time}) - $signed({1'b0, pst_r});
    order_tmo = osv_r && (order_dt > moms_pkg::ORDER_TMO);
    pass_over = pass_dt[31] || (pass_dt > moms_pkg::PASS_TMO);
  end

  // Next mode and timers
  always_comb begin
    mode_nxt = mode_r;
    ost_nxt  = ost_r;
    osv_nxt  = osv_r;
    pst_nxt  = pst_r;
    if (g.restart) begin
      mode_nxt = moms_pkg::OM_INIT;
    end else begin
      unique case (mode_r)
        moms_pkg::OM_INIT: begin
          ost_nxt = g.now_time;
          osv_nxt = 1'b1;
          if (leave_init) mode_nxt = moms_pkg::OM_RUN;
        end
        moms_pkg::OM_RUN: begin
          if (near_target) begin
            if (pass_mode) begin
              mode_nxt = moms_pkg::OM_PASS;
              pst_nxt  = g.now_time;
            end else begin
              mode_nxt = moms_pkg::OM_APPROACH;
            end
          end else if (order_tmo) begin
            mode_nxt = moms_pkg::OM_ERROR;
          end
        end
        moms_pkg::OM_APPROACH: begin
          if (at_target) begin
            mode_nxt = moms_pkg::OM_DONE;
          end else if (order_tmo) begin
            mode_nxt = moms_pkg::OM_ERROR;
          end
        end
        moms_pkg::OM_PASS: begin
          if (pass_over) mode_nxt = moms_pkg::OM_DONE;
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // Advance state and result on each item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= moms_pkg::OM_INIT;
      ost_r  <= '0;
      osv_r  <= 1'b0;
      pst_r  <= '0;
    end else if (upd) begin
      mode_r <= mode_nxt;
      ost_r  <= ost_nxt;
      osv_r  <= osv_nxt;
      pst_r  <= pst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      res_r.order_mode   <= mode_nxt;
      res_r.mode_changed <= mode_nxt != mode_r;
    end
  end

  assign q      = res_r;
  assign mode_o = mode_r;

endmodule
